// File: design/cgs_pkg.sv
// Shared types and constants for the connection group selector.
`timescale 1ns / 1ps
package cgs_pkg;

    localparam int KEY_W          = 64;
    localparam int GROUP_W        = 4;
    localparam int GCOUNT_W       = 5;
    localparam int MAX_GROUPS     = 16;
    localparam int CGS_TABLE_ENTRIES = 64;
    localparam int CGS_REF_BITS   = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = GCOUNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_RR      = 3'd0,
        ST_HIT     = 3'd1,
        ST_NEW     = 3'd2,
        ST_FULL    = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef struct packed {
        logic             peer_valid;
        logic [KEY_W-1:0] host_key;
    } t_in_item;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        t_status            status;
    } t_out_item;

endpackage

// File: design/connection_group_selector_unit.sv
// Top level: request sequencer, table walk and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Round robin, invalid peer or empty table: S_IDLE, S_RESOLVE, then S_OUT.
// Affinity lookup walks the table one entry per cycle through the RAM read
// port, over at most the fill count, so at most TABLE_ENTRIES entries.
// Reset clears the rotation pointer, fill count and mode registers; entries at
// or above the fill count are never read, so the RAM itself is not cleared.
// A stalled result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module connection_group_selector_unit
    import cgs_pkg::*;
#(
    parameter int TABLE_ENTRIES = CGS_TABLE_ENTRIES,
    parameter int REF_BITS      = CGS_REF_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SEARCH  = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_OUT     = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_mode;
    logic [GCOUNT_W-1:0]   r_gcount;
    logic                  r_peer;
    logic [KEY_W-1:0]      r_key;
    logic [FILL_W-1:0]     r_rd_cnt;
    logic                  r_cmp_pend;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic [FILL_W-1:0]     r_fill, n_fill;
    t_out_item             r_res, n_res;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  in_accept;
    logic                  slot_free;
    logic                  hit;
    logic                  more;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_W-1:0]      rd_key;
    logic [GROUP_W-1:0]    rd_group;
    logic [REF_BITS-1:0]   rd_refs;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [GROUP_W-1:0]    wr_group;
    logic [REF_BITS-1:0]   wr_refs;
    logic                  rot_take;
    logic [GROUP_W-1:0]    rot_group;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    cgs_table_ram #(
        .ENTRIES  (TABLE_ENTRIES),
        .REF_BITS (REF_BITS),
        .IDX_W    (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (r_key),
        .i_wr_group (wr_group),
        .i_wr_refs  (wr_refs),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_group (rd_group),
        .o_rd_refs  (rd_refs)
    );

    cgs_rotation u_rotation (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group_count (r_gcount),
        .i_take        (rot_take),
        .o_group       (rot_group)
    );

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_cmp_idx;
        wr_group = rd_group;
        wr_refs  = rd_refs;
        rot_take = 1'b0;
        hit      = (r_state == S_SEARCH) && r_cmp_pend && (rd_key == r_key);
        more     = r_rd_cnt < r_fill;
        // stop issuing reads once a match is seen; the in-flight read is dropped
        rd_en    = (r_state == S_SEARCH) && !hit && more;
        rd_addr  = r_rd_cnt[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (r_mode && i_in_item.peer_valid && (r_fill != '0)) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_RESOLVE;
                    end
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    // bump the reference count in place, saturating
                    wr_en          = 1'b1;
                    wr_refs        = (rd_refs == '1) ? rd_refs : rd_refs + REF_BITS'(1);
                    n_res.group    = rd_group;
                    n_res.status   = ST_HIT;
                    n_state        = S_OUT;
                end else if (!more) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                rot_take    = 1'b1;
                n_res.group = rot_group;
                if (!r_mode) begin
                    n_res.status = ST_RR;
                end else if (!r_peer) begin
                    n_res.status = ST_INVALID;
                end else if (r_fill >= FILL_W'(TABLE_ENTRIES)) begin
                    n_res.status = ST_FULL;
                end else begin
                    // append a fresh entry at the fill point
                    n_res.status = ST_NEW;
                    wr_en        = 1'b1;
                    wr_addr      = r_fill[IDX_W-1:0];
                    wr_group     = rot_group;
                    wr_refs      = '0;
                    n_fill       = r_fill + FILL_W'(1);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_gcount    <= GCOUNT_W'(1);
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_cmp_pend <= rd_en;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCHED_MODE:  r_mode   <= i_cfg_data[0];
                    CFG_GROUP_COUNT: r_gcount <= i_cfg_data[GCOUNT_W-1:0];
                    default:         r_mode   <= r_mode;
                endcase
            end
            if ((r_state == S_OUT) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_accept) begin
            r_peer   <= i_in_item.peer_valid;
            r_key    <= i_in_item.host_key;
            r_rd_cnt <= '0;
        end else if (rd_en) begin
            r_rd_cnt <= r_rd_cnt + FILL_W'(1);
        end
        if (rd_en) begin
            r_cmp_idx <= rd_addr;
        end
        if ((r_state == S_OUT) && slot_free) begin
            r_out_item <= r_res;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_read_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_cnt < r_fill))
        else $error("table read beyond fill count");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |->
            (($past(r_state) == S_RESOLVE) && (r_res.status == ST_NEW)))
        else $error("fill count moved without a new entry");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result register loaded outside the output state");

    a_hit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> (r_state == S_OUT) && (r_res.status == ST_HIT))
        else $error("table hit did not end the walk");
`endif

endmodule

// File: design/cgs_table_ram.sv
// Affinity table storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
module cgs_table_ram
    import cgs_pkg::*;
#(
    parameter int ENTRIES  = CGS_TABLE_ENTRIES,
    parameter int REF_BITS = CGS_REF_BITS,
    parameter int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  logic [KEY_W-1:0]    i_wr_key,
    input  logic [GROUP_W-1:0]  i_wr_group,
    input  logic [REF_BITS-1:0] i_wr_refs,
    input  logic                i_rd_en,
    input  logic [IDX_W-1:0]    i_rd_addr,
    output logic [KEY_W-1:0]    o_rd_key,
    output logic [GROUP_W-1:0]  o_rd_group,
    output logic [REF_BITS-1:0] o_rd_refs
);

    localparam int ROW_W = KEY_W + GROUP_W + REF_BITS;

    logic [ROW_W-1:0] r_mem [ENTRIES];
    logic [ROW_W-1:0] r_rd_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_key, i_wr_group, i_wr_refs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key   = r_rd_row[ROW_W-1 -: KEY_W];
    assign o_rd_group = r_rd_row[REF_BITS +: GROUP_W];
    assign o_rd_refs  = r_rd_row[REF_BITS-1:0];

endmodule

// File: design/cgs_rotation.sv
// Round-robin pointer over the active worker groups.
`timescale 1ns / 1ps
module cgs_rotation
    import cgs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [GCOUNT_W-1:0] i_group_count,
    input  logic                i_take,
    output logic [GROUP_W-1:0]  o_group
);

    logic [GROUP_W-1:0]  r_rot;
    logic [GROUP_W-1:0]  n_rot;
    logic [GCOUNT_W-1:0] active_n;
    logic [GROUP_W-1:0]  cur;

    always_comb begin
        if (i_group_count == '0) begin
            active_n = GCOUNT_W'(1);
        end else if (i_group_count > GCOUNT_W'(MAX_GROUPS)) begin
            active_n = GCOUNT_W'(MAX_GROUPS);
        end else begin
            active_n = i_group_count;
        end
        // pointer left out of range by a lowered count restarts at zero
        cur = ({1'b0, r_rot} >= active_n) ? '0 : r_rot;
        n_rot = (({1'b0, cur} + GCOUNT_W'(1)) >= active_n) ? '0 : cur + GROUP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= '0;
        end else if (i_take) begin
            r_rot <= n_rot;
        end
    end

    assign o_group = cur;

endmodule
